@@ design/first_fit_interval_allocator_macros.svh @@
// assertion macros for the first fit interval allocator
`ifndef FIRST_FIT_INTERVAL_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_INTERVAL_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle
`define FFIA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ffia assertion failed");

// consequent checked in the cycle after the antecedent
`define FFIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ffia assertion failed");

`endif

@@ design/ffia_pkg.sv @@
// shared types and constants of the first fit interval allocator
`timescale 1ns / 1ps

package ffia_pkg;

  localparam int ARG_W     = 16;
  localparam int TAG_W     = 16;
  localparam int OUT_POS_W = 16;
  localparam int LINE_W    = 16;
  localparam int GAP_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic FUNC_PLACE  = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LENGTH = 2'd0,
    CFG_GAP_BEHIND  = 2'd1,
    CFG_GAP_FRONT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_REMOVED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic             func;
    logic [ARG_W-1:0] argument;
  } req_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] start_position;
    status_e              status;
  } rsp_t;

endpackage

@@ design/ffia_store.sv @@
// segment store: one write port, one read port with registered data
`timescale 1ns / 1ps

module ffia_store #(
  parameter int DEPTH = 64,
  parameter int DW    = 48,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/ffia_unit.sv @@
// shared add and compare unit: a + b + c, and whether that sum does not exceed d
`timescale 1ns / 1ps

module ffia_unit #(
  parameter int W = 18
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] c_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] sum_o,
  output logic         fit_o
);

  assign sum_o = a_i + b_i + c_i;
  assign fit_o = (sum_o <= d_i);

endmodule

@@ design/first_fit_interval_allocator.sv @@
// Places and removes segments on a line by first fit over a sorted interval store.
// One request is taken at a time; in_stall_o stays high until its result is
// handed to the output register, which then waits for the consumer while the
// next request may enter. A place request reads one stored interval per cycle
// through the single read port of the segment store until it finds a gap or
// passes the last interval, then moves every interval behind the chosen slot
// up by one entry, one entry per cycle. A full table answers no room without
// scanning. A remove request scans tags one per cycle up to the match and then
// moves the entries behind it down one per cycle. The store needs no clearing
// after reset. Configuration writes are always taken (cfg_ready_o is high) and
// must only be issued while no request is in flight.
`timescale 1ns / 1ps

module first_fit_interval_allocator #(
  parameter int MAX_SEGMENTS   = 64,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ffia_pkg::req_t                     in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ffia_pkg::rsp_t                     out_rsp_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ffia_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ffia_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import ffia_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam int PW = POSITION_WIDTH;
  localparam int CW = ((PW > ARG_W) ? PW : ARG_W) + 2;
  localparam int EW = 2 * PW + TAG_W;
  localparam logic [NW-1:0] MAX_CNT = NW'(MAX_SEGMENTS);
  localparam logic [CW-1:0] POS_MAX = CW'({PW{1'b1}});

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_PSCAN   = 8'b0000_0010,
    S_RSCAN   = 8'b0000_0100,
    S_SHF_PRE = 8'b0000_1000,
    S_SHF     = 8'b0001_0000,
    S_INS     = 8'b0010_0000,
    S_DSH     = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [LINE_W-1:0]  line_len_q, line_len_d;
  logic [GAP_W-1:0]   gap_behind_q, gap_behind_d;
  logic [GAP_W-1:0]   gap_front_q, gap_front_d;
  logic [NW-1:0]      count_q, count_d;
  logic [TAG_W-1:0]   req_num_q, req_num_d;
  logic [ARG_W-1:0]   arg_q, arg_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [NW-1:0]      i_q, i_d;
  logic [NW-1:0]      j_q, j_d;
  logic [NW-1:0]      slot_q, slot_d;
  logic [CW-1:0]      cand_q, cand_d;
  rsp_t               res_q, res_d;
  rsp_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [EW-1:0]      wr_data;
  logic [IW-1:0]      rd_addr;
  logic [EW-1:0]      rd_data;

  logic [PW-1:0]      e_start;
  logic [PW-1:0]      e_end;
  logic [TAG_W-1:0]   e_tag;

  logic [CW-1:0]      op_c, op_d, unit_sum;
  logic               unit_fit;
  logic [CW-1:0]      line_ext, limit;
  logic               at_tail;
  logic [NW-1:0]      i_inc, j_dec, j_dec2, j_inc, j_inc2;
  logic               accept;

  ffia_store #(
    .DEPTH (MAX_SEGMENTS),
    .DW    (EW),
    .AW    (IW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign e_start = rd_data[EW-1 -: PW];
  assign e_end   = rd_data[TAG_W +: PW];
  assign e_tag   = rd_data[TAG_W-1:0];

  assign line_ext = CW'(line_len_q);
  assign limit    = (line_ext < POS_MAX) ? line_ext : POS_MAX;
  assign at_tail  = (i_q == count_q);

  assign op_c = (state_q == S_PSCAN && !at_tail) ? CW'(gap_front_q) : '0;
  assign op_d = at_tail ? limit : CW'(e_start);

  ffia_unit #(
    .W (CW)
  ) u_unit (
    .a_i   (cand_q),
    .b_i   (CW'(arg_q)),
    .c_i   (op_c),
    .d_i   (op_d),
    .sum_o (unit_sum),
    .fit_o (unit_fit)
  );

  assign i_inc  = i_q + NW'(1);
  assign j_dec  = j_q - NW'(1);
  assign j_dec2 = j_q - NW'(2);
  assign j_inc  = j_q + NW'(1);
  assign j_inc2 = j_q + NW'(2);

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    line_len_d   = line_len_q;
    gap_behind_d = gap_behind_q;
    gap_front_d  = gap_front_q;
    count_d      = count_q;
    req_num_d    = req_num_q;
    arg_d        = arg_q;
    tag_d        = tag_q;
    i_d          = i_q;
    j_d          = j_q;
    slot_d       = slot_q;
    cand_d       = cand_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_addr      = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LINE_LENGTH: line_len_d   = cfg_data_i[LINE_W-1:0];
        CFG_GAP_BEHIND:  gap_behind_d = cfg_data_i[GAP_W-1:0];
        CFG_GAP_FRONT:   gap_front_d  = cfg_data_i[GAP_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          arg_d     = in_req_i.argument;
          tag_d     = req_num_q;
          req_num_d = req_num_q + TAG_W'(1);
          i_d       = '0;
          cand_d    = '0;
          if (in_req_i.func == FUNC_REMOVE) begin
            state_d = S_RSCAN;
          end else if (count_q >= MAX_CNT) begin
            res_d   = '{start_position: '0, status: ST_NO_ROOM};
            state_d = S_FIN;
          end else begin
            state_d = S_PSCAN;
          end
        end
      end
      S_PSCAN: begin
        rd_addr = i_inc[IW-1:0];
        if (unit_fit) begin
          slot_d = i_q;
          j_d    = count_q;
          state_d = at_tail ? S_INS : S_SHF_PRE;
        end else if (at_tail) begin
          res_d   = '{start_position: '0, status: ST_NO_ROOM};
          state_d = S_FIN;
        end else begin
          cand_d = CW'(e_end) + CW'(gap_behind_q);
          i_d    = i_inc;
        end
      end
      S_SHF_PRE: begin
        rd_addr = j_dec[IW-1:0];
        state_d = S_SHF;
      end
      S_SHF: begin
        wr_en   = 1'b1;
        wr_addr = j_q[IW-1:0];
        wr_data = rd_data;
        rd_addr = j_dec2[IW-1:0];
        j_d     = j_dec;
        if (j_dec == slot_q) begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = slot_q[IW-1:0];
        wr_data = {cand_q[PW-1:0], unit_sum[PW-1:0], tag_q};
        count_d = count_q + NW'(1);
        res_d   = '{start_position: cand_q[OUT_POS_W-1:0], status: ST_PLACED};
        state_d = S_FIN;
      end
      S_RSCAN: begin
        rd_addr = i_inc[IW-1:0];
        if (at_tail) begin
          res_d   = '{start_position: '0, status: ST_NOT_FOUND};
          state_d = S_FIN;
        end else if (e_tag == arg_q) begin
          if (i_inc == count_q) begin
            count_d = count_q - NW'(1);
            res_d   = '{start_position: '0, status: ST_REMOVED};
            state_d = S_FIN;
          end else begin
            j_d     = i_q;
            state_d = S_DSH;
          end
        end else begin
          i_d = i_inc;
        end
      end
      S_DSH: begin
        wr_en   = 1'b1;
        wr_addr = j_q[IW-1:0];
        wr_data = rd_data;
        rd_addr = j_inc2[IW-1:0];
        j_d     = j_inc;
        if (j_inc2 == count_q) begin
          count_d = count_q - NW'(1);
          res_d   = '{start_position: '0, status: ST_REMOVED};
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      line_len_q   <= '1;
      gap_behind_q <= GAP_W'(1);
      gap_front_q  <= GAP_W'(1);
      count_q      <= '0;
      req_num_q    <= TAG_W'(1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      line_len_q   <= line_len_d;
      gap_behind_q <= gap_behind_d;
      gap_front_q  <= gap_front_d;
      count_q      <= count_d;
      req_num_q    <= req_num_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arg_q  <= arg_d;
    tag_q  <= tag_d;
    i_q    <= i_d;
    j_q    <= j_d;
    slot_q <= slot_d;
    cand_q <= cand_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

@@ design/ffia_checker.sv @@
// port level checks of the first fit interval allocator, bound to the top level
`timescale 1ns / 1ps
`include "first_fit_interval_allocator_macros.svh"

module ffia_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input ffia_pkg::req_t                  in_req_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input ffia_pkg::rsp_t                  out_rsp_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [ffia_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [ffia_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import ffia_pkg::*;

  logic cfg_seen;
  logic req_seen;

  assign cfg_seen = cfg_valid_i && cfg_ready_o && (cfg_index_i != cfg_data_i[CFG_IDX_W-1:0]);
  assign req_seen = in_valid_i && (in_req_i.func == FUNC_PLACE || in_req_i.func == FUNC_REMOVE);

  // a request keeps the block busy for at least the following cycle
  `FFIA_ASSERT_NEXT(a_busy_after_request, clk_i, rst_ni, req_seen && !in_stall_o, in_stall_o)

  // a stalled result holds
  `FFIA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_rsp_o))

  // only a placed segment reports a nonzero start
  `FFIA_ASSERT_NOW(a_start_zero, clk_i, rst_ni,
                   (out_valid_o || cfg_seen) && out_valid_o && out_rsp_o.status != ST_PLACED,
                   out_rsp_o.start_position == '0)

endmodule

bind first_fit_interval_allocator ffia_checker u_ffia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);
